>>> design/tssm_pkg.sv
// Shared constants, codes and control/status types for the three-stack core.
package tssm_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SW     = CNT_W + 2;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    localparam logic [1:0] SEL_LOWER  = 2'd0;
    localparam logic [1:0] SEL_MIDDLE = 2'd1;
    localparam logic [1:0] SEL_UPPER  = 2'd2;
    localparam logic [1:0] SEL_NONE   = 2'd3;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MV_RD,
        ST_MV_WR,
        ST_READ,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP,
        ACT_PEEK,
        ACT_EMPTY,
        ACT_FULL,
        ACT_IGNORE,
        ACT_MOVE
    } act_t;

    typedef enum logic [1:0] {
        TOP_ZERO,
        TOP_VALUE,
        TOP_MEM
    } top_src_t;

    typedef struct packed {
        logic latch_req;
        act_t act;
        logic rd_top;
        logic mv_rd;
        logic mv_wr;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sel_none;
        logic is_push;
        logic is_pop;
        logic fits;
        logic move_ok;
        logic move_trivial;
        logic sel_empty;
        logic mv_last;
    } dp_stat_t;

endpackage

>>> design/three_stacks_shared_memory_core.sv
// Top level of the three-stack core: stream ports, sequencer and datapath.
//
// Three stacks share one 16-entry, 32-bit element memory: the lower stack grows
// up from address 0, the upper stack grows down from the top, and the middle
// stack floats between them. Each input beat pushes, pops or peeks one stack;
// each produces exactly one result beat with a status, the new top of the
// selected stack and all three element counts. A push that finds its slot taken
// recenters the middle stack in the free gap; if that still leaves no room the
// push is refused and nothing changes. Requests are handled one at a time. A
// push that fits, a pop or peek on an empty stack and a beat with no stack
// selected need no memory read; a pop or peek on a non-empty stack or a refused
// push adds one memory read for the top, and a push that relocates the middle
// stack first copies each moved element through the element memory, a read and
// then a write per element, before it is decided again. A finished result
// waits in an output register, so the next beat is accepted while it stalls.
module three_stacks_shared_memory_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // push_value
    input  logic [3:0]  s_axis_tuser,   // req_type[1:0], stack_sel[3:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // top_value[31:0], lower_count[36:32],
                                        // middle_count[41:37], upper_count[46:42], zero
    output logic [1:0]  m_axis_tuser    // status
);
    import tssm_pkg::*;

    ctrl_cmd_t         cmd;
    dp_stat_t          stat;
    logic [1:0]        status;
    logic [DATA_W-1:0] top_value;
    logic [CNT_W-1:0]  lower_count, middle_count, upper_count;

    tssm_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    tssm_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_req_type      (s_axis_tuser[1:0]),
        .in_stack_sel     (s_axis_tuser[3:2]),
        .in_push_value    (s_axis_tdata),
        .out_status       (status),
        .out_top_value    (top_value),
        .out_lower_count  (lower_count),
        .out_middle_count (middle_count),
        .out_upper_count  (upper_count)
    );

    assign m_axis_tdata = {1'b0, upper_count, middle_count, lower_count, top_value};
    assign m_axis_tuser = status;

endmodule

>>> design/tssm_ctrl.sv
// Request sequencer: handshakes, decision per request and relocation stepping.
module tssm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  tssm_pkg::dp_stat_t    stat,
    output tssm_pkg::ctrl_cmd_t   cmd
);
    import tssm_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd.latch_req = 1'b0;
        cmd.act       = ACT_NONE;
        cmd.rd_top    = 1'b0;
        cmd.mv_rd     = 1'b0;
        cmd.mv_wr     = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (stat.sel_none) begin
                    cmd.act    = ACT_IGNORE;
                    state_next = ST_DONE;
                end else if (stat.is_push) begin
                    if (stat.fits) begin
                        cmd.act    = ACT_PUSH;
                        state_next = ST_DONE;
                    end else if (stat.move_ok) begin
                        cmd.act    = ACT_MOVE;
                        state_next = stat.move_trivial ? ST_EVAL : ST_MV_RD;
                    end else begin
                        cmd.act    = ACT_FULL;
                        state_next = ST_READ;
                    end
                end else if (stat.sel_empty) begin
                    cmd.act    = ACT_EMPTY;
                    state_next = ST_DONE;
                end else if (stat.is_pop) begin
                    cmd.act    = ACT_POP;
                    state_next = ST_READ;
                end else begin
                    cmd.act    = ACT_PEEK;
                    state_next = ST_READ;
                end
            end
            ST_MV_RD: begin
                cmd.mv_rd  = 1'b1;
                state_next = ST_MV_WR;
            end
            ST_MV_WR: begin
                cmd.mv_wr  = 1'b1;
                state_next = stat.mv_last ? ST_EVAL : ST_MV_RD;
            end
            ST_READ: begin
                cmd.rd_top = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

endmodule

>>> design/tssm_dpath.sv
// Stack pointers, element memory, relocation arithmetic and result register.
module tssm_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tssm_pkg::ctrl_cmd_t          cmd,
    output tssm_pkg::dp_stat_t           stat,
    input  logic [1:0]                   in_req_type,
    input  logic [1:0]                   in_stack_sel,
    input  logic [tssm_pkg::DATA_W-1:0]  in_push_value,
    output logic [1:0]                   out_status,
    output logic [tssm_pkg::DATA_W-1:0]  out_top_value,
    output logic [tssm_pkg::CNT_W-1:0]   out_lower_count,
    output logic [tssm_pkg::CNT_W-1:0]   out_middle_count,
    output logic [tssm_pkg::CNT_W-1:0]   out_upper_count
);
    import tssm_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [1:0]        req_type_reg;
    logic [1:0]        stack_sel_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]  lower_reg, middle_reg, upper_reg;
    logic [AW-1:0]     base_reg;
    logic [AW-1:0]     mv_src_reg, mv_dst_reg;
    logic [CNT_W-1:0]  mv_cnt_reg;
    logic              mv_down_reg;
    logic [1:0]        res_status_reg;
    top_src_t          top_src_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_top_reg;
    logic [CNT_W-1:0]  out_lower_reg, out_middle_reg, out_upper_reg;

    logic [CNT_W-1:0]  e_pos;
    logic [CNT_W:0]    mid_end;
    logic [CNT_W:0]    e_ext;
    logic [CNT_W-1:0]  sel_cnt;
    logic signed [SW-1:0] l_s, m_s, e_s, d_s, g_s, nb_s, nb_end_s;
    logic [AW-1:0]     nb;
    logic [AW-1:0]     src_hi, dst_hi;
    logic [AW-1:0]     push_addr, top_addr;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] top_final;

    assign e_pos   = DEPTH_C - upper_reg;
    assign mid_end = (CNT_W + 1)'(base_reg) + (CNT_W + 1)'(middle_reg);
    assign e_ext   = (CNT_W + 1)'(e_pos);

    always_comb begin
        case (stack_sel_reg)
            SEL_LOWER:  sel_cnt = lower_reg;
            SEL_MIDDLE: sel_cnt = middle_reg;
            SEL_UPPER:  sel_cnt = upper_reg;
            default:    sel_cnt = '0;
        endcase
    end

    assign l_s      = $signed({2'b00, lower_reg});
    assign m_s      = $signed({2'b00, middle_reg});
    assign e_s      = $signed({2'b00, e_pos});
    assign d_s      = e_s - SW'(1) - l_s;
    assign g_s      = l_s + ((d_s > 0) ? (d_s >>> 1) : SW'(0));
    assign nb_s     = g_s - ((m_s + SW'(1)) >>> 1);
    assign nb_end_s = nb_s + m_s;
    assign nb       = nb_s[AW-1:0];

    assign src_hi = AW'(mid_end - (CNT_W + 1)'(1));
    assign dst_hi = AW'((CNT_W + 1)'(nb) + (CNT_W + 1)'(middle_reg) - (CNT_W + 1)'(1));

    assign stat.sel_none     = (stack_sel_reg == SEL_NONE);
    assign stat.is_push      = (req_type_reg == REQ_PUSH);
    assign stat.is_pop       = (req_type_reg == REQ_POP);
    assign stat.fits         = (stack_sel_reg == SEL_LOWER) ?
                               (lower_reg < CNT_W'(base_reg)) : (mid_end < e_ext);
    assign stat.move_ok      = !(nb_s < l_s || nb_end_s > e_s) &&
                               ((stack_sel_reg == SEL_LOWER) ? (l_s < nb_s) : (nb_end_s < e_s));
    assign stat.move_trivial = (middle_reg == '0) || (nb == base_reg);
    assign stat.sel_empty    = (sel_cnt == '0);
    assign stat.mv_last      = (mv_cnt_reg == CNT_W'(1));

    always_comb begin
        case (stack_sel_reg)
            SEL_LOWER: begin
                push_addr = lower_reg[AW-1:0];
                top_addr  = AW'(lower_reg - CNT_W'(1));
            end
            SEL_MIDDLE: begin
                push_addr = mid_end[AW-1:0];
                top_addr  = src_hi;
            end
            default: begin
                push_addr = AW'(e_pos - CNT_W'(1));
                top_addr  = e_pos[AW-1:0];
            end
        endcase
    end

    assign we    = (cmd.act == ACT_PUSH) || cmd.mv_wr;
    assign waddr = cmd.mv_wr ? mv_dst_reg : push_addr;
    assign wdata = cmd.mv_wr ? rdata_reg : value_reg;
    assign re    = cmd.rd_top || cmd.mv_rd;
    assign raddr = cmd.mv_rd ? mv_src_reg : top_addr;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg  <= '0;
            middle_reg <= '0;
            upper_reg  <= '0;
            base_reg   <= AW'(DEPTH / 2);
        end else begin
            case (cmd.act)
                ACT_PUSH: begin
                    case (stack_sel_reg)
                        SEL_LOWER:  lower_reg  <= lower_reg + CNT_W'(1);
                        SEL_MIDDLE: middle_reg <= middle_reg + CNT_W'(1);
                        default:    upper_reg  <= upper_reg + CNT_W'(1);
                    endcase
                end
                ACT_POP: begin
                    case (stack_sel_reg)
                        SEL_LOWER:  lower_reg  <= lower_reg - CNT_W'(1);
                        SEL_MIDDLE: middle_reg <= middle_reg - CNT_W'(1);
                        default:    upper_reg  <= upper_reg - CNT_W'(1);
                    endcase
                end
                ACT_MOVE: begin
                    base_reg <= nb;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_type_reg  <= in_req_type;
            stack_sel_reg <= in_stack_sel;
            value_reg     <= in_push_value;
        end
        if (cmd.act == ACT_MOVE) begin
            mv_down_reg <= (nb > base_reg);
            mv_cnt_reg  <= middle_reg;
            mv_src_reg  <= (nb > base_reg) ? src_hi : base_reg;
            mv_dst_reg  <= (nb > base_reg) ? dst_hi : nb;
        end else if (cmd.mv_wr) begin
            mv_cnt_reg <= mv_cnt_reg - CNT_W'(1);
            if (mv_down_reg) begin
                mv_src_reg <= mv_src_reg - AW'(1);
                mv_dst_reg <= mv_dst_reg - AW'(1);
            end else begin
                mv_src_reg <= mv_src_reg + AW'(1);
                mv_dst_reg <= mv_dst_reg + AW'(1);
            end
        end
        case (cmd.act)
            ACT_PUSH: begin
                res_status_reg <= STAT_DONE;
                top_src_reg    <= TOP_VALUE;
            end
            ACT_POP, ACT_PEEK: begin
                res_status_reg <= STAT_DONE;
                top_src_reg    <= TOP_MEM;
            end
            ACT_EMPTY: begin
                res_status_reg <= STAT_EMPTY;
                top_src_reg    <= TOP_ZERO;
            end
            ACT_FULL: begin
                res_status_reg <= STAT_FULL;
                top_src_reg    <= TOP_MEM;
            end
            ACT_IGNORE: begin
                res_status_reg <= STAT_DONE;
                top_src_reg    <= TOP_ZERO;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (top_src_reg)
            TOP_VALUE: top_final = value_reg;
            TOP_MEM:   top_final = (sel_cnt != '0) ? rdata_reg : '0;
            default:   top_final = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_top_reg    <= top_final;
            out_lower_reg  <= lower_reg;
            out_middle_reg <= middle_reg;
            out_upper_reg  <= upper_reg;
        end
    end

    assign out_status       = out_status_reg;
    assign out_top_value    = out_top_reg;
    assign out_lower_count  = out_lower_reg;
    assign out_middle_count = out_middle_reg;
    assign out_upper_count  = out_upper_reg;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the three-stack shared-memory core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tssm_pkg::*;

    localparam logic [1:0] REQ_PEEK_ALT   = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 60;
    localparam int         RANDOM_PHASES  = 10;
    localparam int         PHASE_ITEMS    = 40;

    typedef struct {
        logic [1:0]       status;
        logic [DATA_W-1:0] top;
        logic [4:0]       lower;
        logic [4:0]       middle;
        logic [4:0]       upper;
    } stack_result_t;

    class stack_scoreboard;
        logic [DATA_W-1:0] mem [DEPTH];
        int lower_n;
        int mid_n;
        int upper_n;
        int mid_base;
        stack_result_t pending[$];
        int errors;
        int requests;
        int refused;
        int moves;
        int empties;
        int ignored;

        function new();
            foreach (mem[i]) mem[i] = '0;
            lower_n  = 0;
            mid_n    = 0;
            upper_n  = 0;
            mid_base = DEPTH / 2;
            errors   = 0;
            requests = 0;
            refused  = 0;
            moves    = 0;
            empties  = 0;
            ignored  = 0;
        endfunction

        // recenter the middle stack in the free gap; refuse if the pusher still has no slot
        function bit recenter_middle(logic [1:0] sel);
            int l;
            int m;
            int e;
            int d;
            int g;
            int nb;
            logic [DATA_W-1:0] tmp [DEPTH];
            l  = lower_n;
            m  = mid_n;
            e  = DEPTH - upper_n;
            d  = e - 1 - l;
            g  = l + (d > 0 ? d / 2 : 0);
            nb = g - (m + 1) / 2;
            if (nb < l || nb + m > e) return 1'b0;
            if (sel == SEL_LOWER ? !(l < nb) : !(nb + m < e)) return 1'b0;
            for (int i = 0; i < m; i++) tmp[i] = mem[mid_base + i];
            for (int i = 0; i < m; i++) mem[nb + i] = tmp[i];
            mid_base = nb;
            moves++;
            return 1'b1;
        endfunction

        function void note_request(logic [1:0] req, logic [1:0] sel, logic [DATA_W-1:0] val);
            stack_result_t r;
            int e;
            int cnt;
            bit ok;
            r.status = STAT_DONE;
            r.top    = '0;
            requests++;
            if (sel == SEL_NONE) begin
                ignored++;
            end else begin
                cnt = (sel == SEL_LOWER) ? lower_n : (sel == SEL_MIDDLE) ? mid_n : upper_n;
                if (req == REQ_PUSH) begin
                    e  = DEPTH - upper_n;
                    ok = 1'b1;
                    if (sel == SEL_LOWER) begin
                        if (!(lower_n < mid_base)) ok = recenter_middle(sel);
                        if (ok) begin
                            mem[lower_n] = val;
                            lower_n++;
                        end
                    end else begin
                        if (!(mid_base + mid_n < e)) ok = recenter_middle(sel);
                        if (ok && sel == SEL_MIDDLE) begin
                            mem[mid_base + mid_n] = val;
                            mid_n++;
                        end else if (ok) begin
                            mem[e - 1] = val;
                            upper_n++;
                        end
                    end
                    if (!ok) begin
                        r.status = STAT_FULL;
                        refused++;
                    end
                end else if (cnt == 0) begin
                    r.status = STAT_EMPTY;
                    empties++;
                end else if (req == REQ_POP) begin
                    case (sel)
                        SEL_LOWER:  lower_n--;
                        SEL_MIDDLE: mid_n--;
                        default:    upper_n--;
                    endcase
                end
                case (sel)
                    SEL_LOWER:  r.top = lower_n ? mem[lower_n - 1] : '0;
                    SEL_MIDDLE: r.top = mid_n ? mem[mid_base + mid_n - 1] : '0;
                    default:    r.top = upper_n ? mem[DEPTH - upper_n] : '0;
                endcase
            end
            r.lower  = lower_n[4:0];
            r.middle = mid_n[4:0];
            r.upper  = upper_n[4:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [47:0] data, logic [1:0] user);
            stack_result_t r;
            if (pending.size() == 0) begin
                $error("result beat with no request outstanding: tdata=%h tuser=%h", data, user);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (user !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, user);
                errors++;
            end
            if (data[31:0] !== r.top) begin
                $error("top_value: expected %h, actual %h", r.top, data[31:0]);
                errors++;
            end
            if (data[36:32] !== r.lower) begin
                $error("lower_count: expected %0d, actual %0d", r.lower, data[36:32]);
                errors++;
            end
            if (data[41:37] !== r.middle) begin
                $error("middle_count: expected %0d, actual %0d", r.middle, data[41:37]);
                errors++;
            end
            if (data[46:42] !== r.upper) begin
                $error("upper_count: expected %0d, actual %0d", r.upper, data[46:42]);
                errors++;
            end
            if (data[47] !== 1'b0) begin
                $error("pad: expected 0, actual %b", data[47]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    stack_scoreboard sb;
    int idle_cycles = 0;
    int burst_left = 0;

    int rx_mode = 0;
    int rx_left = 0;
    int rx_period = 1;
    int rx_phase = 0;

    three_stacks_shared_memory_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    // sample both channels
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sb.note_request(s_axis_tuser[1:0], s_axis_tuser[3:2], s_axis_tdata);
        end
        if (aresetn && ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver backpressure in segments of differing style
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            rx_left   = $urandom_range(5, 60);
            rx_period = $urandom_range(2, 8);
            rx_phase  = 0;
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= (rx_phase % rx_period) == 0;
            default: m_axis_tready <= (rx_phase > 15);
        endcase
    end

    // drive one beat from a falling edge and return at the falling edge after its acceptance or after a random idle gap
    task automatic send_beat(logic [1:0] req, logic [1:0] sel, logic [31:0] val);
        int gap;
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = {sel, req};
        s_axis_tdata  = val;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int push_weight;
        int roll;
        logic [1:0] req;
        logic [1:0] sel;
        logic [31:0] val;
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty stacks, ignored selector
        send_beat(REQ_POP, SEL_LOWER, 32'h0);
        send_beat(REQ_POP, SEL_MIDDLE, 32'h0);
        send_beat(REQ_POP, SEL_UPPER, 32'h0);
        send_beat(REQ_PEEK, SEL_LOWER, 32'h0);
        send_beat(REQ_PEEK, SEL_MIDDLE, 32'h0);
        send_beat(REQ_PEEK_ALT, SEL_UPPER, 32'hFFFF_FFFF);
        send_beat(REQ_PUSH, SEL_NONE, 32'hFFFF_FFFF);
        send_beat(REQ_POP, SEL_NONE, 32'h0);
        // extremes, then grow the lower stack into the middle one to force a move
        send_beat(REQ_PUSH, SEL_MIDDLE, 32'h0000_0000);
        send_beat(REQ_PUSH, SEL_UPPER, 32'hFFFF_FFFF);
        for (int i = 0; i < 9; i++) begin
            send_beat(REQ_PUSH, SEL_LOWER, (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
        end
        send_beat(REQ_PEEK_ALT, SEL_MIDDLE, 32'h0);
        send_beat(REQ_POP, SEL_MIDDLE, 32'h0);
        send_beat(REQ_POP, SEL_UPPER, 32'h0);
        send_beat(REQ_POP, SEL_LOWER, 32'h8000_0001);

        // random phases alternating between filling up and draining
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0:       push_weight = 90;
                1:       push_weight = 30;
                2:       push_weight = 70;
                default: push_weight = 20;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                sel  = ($urandom_range(0, 24) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
                if (roll < push_weight) begin
                    req = REQ_PUSH;
                end else if (roll < push_weight + (100 - push_weight) * 2 / 3) begin
                    req = REQ_POP;
                end else begin
                    req = ($urandom_range(0, 3) == 0) ? REQ_PEEK_ALT : REQ_PEEK;
                end
                case ($urandom_range(0, 9))
                    0:       val = 32'h0;
                    1:       val = 32'hFFFF_FFFF;
                    default: val = $urandom;
                endcase
                send_beat(req, sel, val);
            end
        end
        s_axis_tvalid = 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d middle-stack moves, %0d refused pushes,",
                 sb.requests, sb.moves, sb.refused);
        $display("%0d pops or peeks on empty stacks, %0d beats with no stack selected",
                 sb.empties, sb.ignored);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
design/tssm_pkg.sv
design/tssm_ctrl.sv
design/tssm_dpath.sv
design/three_stacks_shared_memory_core.sv
tb/tb.sv
